>>> sv/spxr_pkg.sv
`timescale 1ns / 1ps
package spxr_pkg;

  localparam int HALF_BITS      = 32;
  localparam int WORD_BITS      = 2 * HALF_BITS;
  localparam int NIB_BITS       = 4;
  localparam int NIB_COUNT      = HALF_BITS / NIB_BITS;
  localparam int SBOX_BITS      = 64;
  localparam int DST_BITS       = 5;
  localparam int ENTRIES_PER_REG = 8;
  localparam int PERM_REG_BITS  = DST_BITS * ENTRIES_PER_REG;
  localparam int PERM_REGS      = 4;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_SBOX  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PERM0 = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PERM1 = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PERM2 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PERM3 = 3'd4;

  localparam logic [SBOX_BITS-1:0]     SBOX_RST  = 64'd15454431203957939955;
  localparam logic [PERM_REG_BITS-1:0] PERM0_RST = 40'd814622558768;
  localparam logic [PERM_REG_BITS-1:0] PERM1_RST = 40'd530877622568;
  localparam logic [PERM_REG_BITS-1:0] PERM2_RST = 40'd247132686368;
  localparam logic [PERM_REG_BITS-1:0] PERM3_RST = 40'd1098367494968;

  typedef logic [SBOX_BITS-1:0]                     sbox_tbl_t;
  typedef logic [PERM_REGS-1:0][PERM_REG_BITS-1:0]  perm_map_t;
  typedef logic [HALF_BITS-1:0]                     half_t;

endpackage

>>> sv/sbox_player_xor_round.sv
`timescale 1ns / 1ps
// An accepted beat is held in the input register and then in the result register, which drives out_* and out_valid.
// Throughput: one beat per cycle; busy is never raised and the receiver cannot stall.
// The word is registered on accept; both S-box layers, both permutations and the XORs
// sit between that input register and the result register.
// Reset (rst_n low, synchronous) clears the valid bits and loads the default S-box
// and permutation tables; data registers are not reset.
module sbox_player_xor_round (
  input  logic                                clk,
  input  logic                                rst_n,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic [spxr_pkg::WORD_BITS-1:0]      in_block_in,
  // result channel
  output logic                                out_valid,
  output logic [spxr_pkg::HALF_BITS-1:0]      out_perm_half,
  output logic [spxr_pkg::HALF_BITS-1:0]      out_sub_half,
  // config write port
  input  logic                                cfg_we,
  input  logic [spxr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [spxr_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  // Config registers
  spxr_pkg::sbox_tbl_t sbox_r;
  spxr_pkg::perm_map_t perm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sbox_r    <= spxr_pkg::SBOX_RST;
      perm_r[0] <= spxr_pkg::PERM0_RST;
      perm_r[1] <= spxr_pkg::PERM1_RST;
      perm_r[2] <= spxr_pkg::PERM2_RST;
      perm_r[3] <= spxr_pkg::PERM3_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        spxr_pkg::CFG_SBOX:  sbox_r    <= cfg_data[spxr_pkg::SBOX_BITS-1:0];
        spxr_pkg::CFG_PERM0: perm_r[0] <= cfg_data[spxr_pkg::PERM_REG_BITS-1:0];
        spxr_pkg::CFG_PERM1: perm_r[1] <= cfg_data[spxr_pkg::PERM_REG_BITS-1:0];
        spxr_pkg::CFG_PERM2: perm_r[2] <= cfg_data[spxr_pkg::PERM_REG_BITS-1:0];
        spxr_pkg::CFG_PERM3: perm_r[3] <= cfg_data[spxr_pkg::PERM_REG_BITS-1:0];
        default: ;  // index past the list: ignored
      endcase
    end
  end

  // Never stalls: a new beat is taken every cycle
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Input register: accepted word and its valid bit
  logic                           in_v_r;
  logic [spxr_pkg::WORD_BITS-1:0] blk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      blk_r <= in_block_in;
    end
  end

  // First layer: S from upper half, P from lower half
  spxr_pkg::half_t s_w, p_w;

  spxr_sub u_sub_a (
    .tbl  (sbox_r),
    .din  (blk_r[spxr_pkg::WORD_BITS-1:spxr_pkg::HALF_BITS]),
    .dout (s_w)
  );

  spxr_perm u_perm_a (
    .map  (perm_r),
    .din  (blk_r[spxr_pkg::HALF_BITS-1:0]),
    .dout (p_w)
  );

  spxr_pkg::half_t x1_w, x2_w;

  assign x1_w = s_w ^ p_w;
  assign x2_w = s_w ^ x1_w;  // equals P

  // Second layer: S-box on x1, permutation on x2
  spxr_pkg::half_t sub_nxt, perm_nxt;

  spxr_sub u_sub_b (
    .tbl  (sbox_r),
    .din  (x1_w),
    .dout (sub_nxt)
  );

  spxr_perm u_perm_b (
    .map  (perm_r),
    .din  (x2_w),
    .dout (perm_nxt)
  );

  logic            out_valid_r;
  spxr_pkg::half_t sub_r, perm_half_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_v_r) begin
      sub_r       <= sub_nxt;
      perm_half_r <= perm_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sub_half  = sub_r;
  assign out_perm_half = perm_half_r;

  // Checks
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r |=> out_valid_r)
    else $error("input beat did not reach result register");

  a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(in_v_r))
    else $error("result strobe without an input beat");

  a_out_from_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(start, 2))
    else $error("result strobe without a command two cycles back");

endmodule

>>> sv/spxr_sub.sv
`timescale 1ns / 1ps
// Nibble-wise S-box layer over one half word
module spxr_sub (
  input  spxr_pkg::sbox_tbl_t tbl,
  input  spxr_pkg::half_t     din,
  output spxr_pkg::half_t     dout
);

  always_comb begin
    logic [spxr_pkg::NIB_BITS-1:0] nib;
    dout = '0;
    for (int n = 0; n < spxr_pkg::NIB_COUNT; n++) begin
      nib = din[n*spxr_pkg::NIB_BITS +: spxr_pkg::NIB_BITS];
      dout[n*spxr_pkg::NIB_BITS +: spxr_pkg::NIB_BITS] =
        tbl[{nib, 2'b00} +: spxr_pkg::NIB_BITS];
    end
  end

endmodule

>>> sv/spxr_perm.sv
`timescale 1ns / 1ps
// 32-bit bit permutation; colliding destinations OR together
module spxr_perm (
  input  spxr_pkg::perm_map_t map,
  input  spxr_pkg::half_t     din,
  output spxr_pkg::half_t     dout
);

  always_comb begin
    logic [spxr_pkg::DST_BITS-1:0] dst;
    dout = '0;
    for (int src = 0; src < spxr_pkg::HALF_BITS; src++) begin
      dst = map[src >> 3][(src & 7) * spxr_pkg::DST_BITS +: spxr_pkg::DST_BITS];
      dout[dst] = dout[dst] | din[src];
    end
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
module testbench;

  // Cycles with neither an accepted command nor a result before the run is declared hung.
  localparam int QUIET_LIMIT = 2000;
  localparam int SHOW_LIMIT  = 10;
  // Cycles allowed after the last result before tables change; the round has two stages.
  localparam int SETTLE_CYCLES = 4;
  // Bits of a routing write that land above the 40-bit register
  localparam int SPILL_BITS = spxr_pkg::CFG_DATA_BITS - spxr_pkg::PERM_REG_BITS;

  typedef struct packed {
    spxr_pkg::half_t perm_half;
    spxr_pkg::half_t sub_half;
  } round_out_t;

  logic                               clk         = 1'b0;
  logic                               rst_n       = 1'b0;
  logic                               start       = 1'b0;
  logic                               busy;
  logic [spxr_pkg::WORD_BITS-1:0]     in_block_in = '0;
  logic                               out_valid;
  spxr_pkg::half_t                    out_perm_half;
  spxr_pkg::half_t                    out_sub_half;
  logic                               cfg_we      = 1'b0;
  logic [spxr_pkg::CFG_IDX_BITS-1:0]  cfg_index   = '0;
  logic [spxr_pkg::CFG_DATA_BITS-1:0] cfg_data    = '0;

  // Shadow copies of the block's tables, updated as they are written.
  spxr_pkg::sbox_tbl_t sbox_now;
  spxr_pkg::perm_map_t route_now;

  logic [spxr_pkg::WORD_BITS-1:0] word_q[$];     // words waiting to be issued
  round_out_t                     round_due[$];  // predicted round outputs, oldest first

  int sender_idle_pct = 0;
  bit drain_hold      = 1'b0;  // sender holds off until every due result is back
  int mismatches      = 0;
  int quiet_cycles    = 0;

  sbox_player_xor_round u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_block_in  (in_block_in),
    .out_valid    (out_valid),
    .out_perm_half(out_perm_half),
    .out_sub_half (out_sub_half),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Round predictor
  // ---------------------------------------------------------------------------

  // Nibble-wise S-box lookup over one half word.
  function automatic spxr_pkg::half_t nibble_sub(input spxr_pkg::half_t v);
    spxr_pkg::half_t r;
    int              n;
    r = '0;
    for (n = 0; n < spxr_pkg::NIB_COUNT; n++) begin
      r[spxr_pkg::NIB_BITS*n +: spxr_pkg::NIB_BITS] =
        sbox_now[spxr_pkg::NIB_BITS*v[spxr_pkg::NIB_BITS*n +: spxr_pkg::NIB_BITS]
                 +: spxr_pkg::NIB_BITS];
    end
    return r;
  endfunction

  // Bit routing: source bit goes to the 5-bit destination held for it.
  // Two sources landing on one destination OR together.
  function automatic spxr_pkg::half_t bit_route(input spxr_pkg::half_t v);
    spxr_pkg::half_t               r;
    int                            src;
    logic [spxr_pkg::DST_BITS-1:0] dst;
    r = '0;
    for (src = 0; src < spxr_pkg::HALF_BITS; src++) begin
      dst = route_now[src / spxr_pkg::ENTRIES_PER_REG]
                     [spxr_pkg::DST_BITS*(src % spxr_pkg::ENTRIES_PER_REG)
                      +: spxr_pkg::DST_BITS];
      if (v[src] && dst < spxr_pkg::HALF_BITS) r[dst] = 1'b1;
    end
    return r;
  endfunction

  function automatic round_out_t spn_round(input logic [spxr_pkg::WORD_BITS-1:0] w);
    spxr_pkg::half_t s, p, x1, x2;
    round_out_t      o;
    s  = nibble_sub(w[spxr_pkg::WORD_BITS-1:spxr_pkg::HALF_BITS]);
    p  = bit_route(w[spxr_pkg::HALF_BITS-1:0]);
    x1 = s ^ p;
    x2 = s ^ x1;  // recovers p
    o.perm_half = bit_route(x2);
    o.sub_half  = nibble_sub(x1);
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: issues queued words, predicts on each accepted beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        round_due.push_back(spn_round(in_block_in));
        void'(word_q.pop_front());
        // now and then stop feeding until the pipe is empty
        if ($urandom_range(149) == 0) drain_hold = 1'b1;
      end
      if (drain_hold && round_due.size() == 0) drain_hold = 1'b0;
      // a command not yet taken stays up unchanged
      if (!(start && busy)) begin
        if (word_q.size() > 0 && !drain_hold && $urandom_range(99) >= sender_idle_pct) begin
          start       <= 1'b1;
          in_block_in <= word_q[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed result is matched against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    round_out_t want;
    if (rst_n && out_valid) begin
      if (round_due.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("unexpected result beat: perm_half %h sub_half %h",
                   out_perm_half, out_sub_half);
      end else begin
        want = round_due.pop_front();
        if (want.perm_half !== out_perm_half || want.sub_half !== out_sub_half) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT)
            $display("result mismatch: perm_half exp %h got %h, sub_half exp %h got %h",
                     want.perm_half, out_perm_half, want.sub_half, out_sub_half);
        end
      end
    end
  end

  // Watchdog on forward progress.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Table writes and stimulus phases
  // ---------------------------------------------------------------------------

  task automatic write_reg(input logic [spxr_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [spxr_pkg::CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      spxr_pkg::CFG_SBOX: begin
        sbox_now = data;
      end
      spxr_pkg::CFG_PERM0, spxr_pkg::CFG_PERM1, spxr_pkg::CFG_PERM2,
      spxr_pkg::CFG_PERM3: begin
        // bits above the register width are dropped
        route_now[idx - spxr_pkg::CFG_PERM0] = data[spxr_pkg::PERM_REG_BITS-1:0];
      end
      default: begin
        // index past the table: no register behind it
      end
    endcase
  endtask

  // Loads all tables; spill lands above the 40-bit routing registers, and every
  // unmapped index gets a junk write that must not disturb anything.
  task automatic load_tables(input spxr_pkg::sbox_tbl_t sbox,
                             input spxr_pkg::perm_map_t route,
                             input logic [SPILL_BITS-1:0] spill);
    int k;
    int idx;
    write_reg(spxr_pkg::CFG_SBOX, sbox);
    for (k = 0; k < spxr_pkg::PERM_REGS; k++)
      write_reg(spxr_pkg::CFG_PERM0 + k[spxr_pkg::CFG_IDX_BITS-1:0], {spill, route[k]});
    for (idx = spxr_pkg::CFG_PERM3 + 1; idx < (1 << spxr_pkg::CFG_IDX_BITS); idx++)
      write_reg(idx[spxr_pkg::CFG_IDX_BITS-1:0], {$urandom, $urandom});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait for the pipe to empty, plus a margin for anything still in flight.
  task automatic settle();
    while (word_q.size() != 0 || round_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Field extremes, alternating patterns, single bits at the half boundaries.
  task automatic push_corners();
    word_q.push_back(64'h0000_0000_0000_0000);
    word_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    word_q.push_back(64'hFFFF_FFFF_0000_0000);
    word_q.push_back(64'h0000_0000_FFFF_FFFF);
    word_q.push_back(64'hAAAA_AAAA_5555_5555);
    word_q.push_back(64'h5555_5555_AAAA_AAAA);
    word_q.push_back(64'h0123_4567_89AB_CDEF);
    word_q.push_back(64'hFEDC_BA98_7654_3210);
    word_q.push_back(64'h8000_0000_0000_0001);
    word_q.push_back(64'h0000_0001_8000_0000);
    word_q.push_back(64'h0000_000F_F000_0000);
    settle();
  endtask

  // Random words, with a share of one-sided and single-bit words mixed in.
  task automatic run_batch(input int count, input int idle_pct);
    logic [spxr_pkg::WORD_BITS-1:0] w;
    sender_idle_pct = idle_pct;
    repeat (count) begin
      w = {$urandom, $urandom};
      case ($urandom_range(7))
        0:       w[spxr_pkg::WORD_BITS-1:spxr_pkg::HALF_BITS] = '0;
        1:       w[spxr_pkg::HALF_BITS-1:0] = '0;
        2:       w = 64'd1 << $urandom_range(spxr_pkg::WORD_BITS - 1);
        default: ;
      endcase
      word_q.push_back(w);
    end
    settle();
  endtask

  initial begin
    spxr_pkg::sbox_tbl_t sbox;
    spxr_pkg::perm_map_t route;
    int                  i;
    int                  j;

    sbox_now     = spxr_pkg::SBOX_RST;
    route_now[0] = spxr_pkg::PERM0_RST;
    route_now[1] = spxr_pkg::PERM1_RST;
    route_now[2] = spxr_pkg::PERM2_RST;
    route_now[3] = spxr_pkg::PERM3_RST;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset tables: corners, then back-to-back random traffic
    sender_idle_pct = 0;
    push_corners();
    run_batch(150, 0);

    // identity S-box and routing, sparse sender
    for (i = 0; i < 16; i++) sbox[4*i +: 4] = i[spxr_pkg::NIB_BITS-1:0];
    for (i = 0; i < spxr_pkg::HALF_BITS; i++)
      route[i / spxr_pkg::ENTRIES_PER_REG]
           [spxr_pkg::DST_BITS*(i % spxr_pkg::ENTRIES_PER_REG) +: spxr_pkg::DST_BITS] =
        i[spxr_pkg::DST_BITS-1:0];
    load_tables(sbox, route, '0);
    run_batch(150, 77);

    // everything collides on bit 0 and the S-box is all zeros
    load_tables('0, '0, '1);
    sender_idle_pct = 0;
    push_corners();
    run_batch(150, 0);

    // everything collides on bit 31 and the S-box is all ones
    load_tables('1, '1, '1);
    run_batch(150, 23);

    // reversed routing with a random S-box
    for (i = 0; i < spxr_pkg::HALF_BITS; i++) begin
      j = spxr_pkg::HALF_BITS - 1 - i;
      route[i / spxr_pkg::ENTRIES_PER_REG]
           [spxr_pkg::DST_BITS*(i % spxr_pkg::ENTRIES_PER_REG) +: spxr_pkg::DST_BITS] =
        j[spxr_pkg::DST_BITS-1:0];
    end
    load_tables({$urandom, $urandom}, route, SPILL_BITS'($urandom));
    run_batch(150, 77);

    // fully random tables, usually with colliding destinations
    load_tables({$urandom, $urandom}, {$urandom, $urandom, $urandom, $urandom, $urandom},
                SPILL_BITS'($urandom));
    run_batch(150, 23);
    load_tables({$urandom, $urandom}, {$urandom, $urandom, $urandom, $urandom, $urandom},
                SPILL_BITS'($urandom));
    run_batch(150, 0);

    // reset values written back explicitly
    load_tables(spxr_pkg::SBOX_RST,
                {spxr_pkg::PERM3_RST, spxr_pkg::PERM2_RST,
                 spxr_pkg::PERM1_RST, spxr_pkg::PERM0_RST}, '0);
    run_batch(150, 23);

    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/spxr_pkg.sv
sv/spxr_sub.sv
sv/spxr_perm.sv
sv/sbox_player_xor_round.sv
test/testbench.sv
